// ===== rtl/core/occ_pkg.sv =====
// ----------------------------------------------------------------------------
// occ_pkg
// Shared types and constants of the occupancy grid store: channel payloads,
// item kinds and the entry that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package occ_pkg;

  // Widest coordinate inside any supported grid (up to 127 columns or rows)
  localparam int CRD_W       = 7;
  // Coordinate width on the result channel
  localparam int NB_OUT_W    = 6;
  // Number of four-neighbours of a cell
  localparam int NB_N        = 4;
  // Entries between front and back
  localparam int QUEUE_DEPTH = 2;
  // Configuration register data width
  localparam int CFG_W       = 7;

  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_NBR   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic              obstacle_value;
    logic              skip_blocked;
  } in_item_t;

  typedef struct packed {
    logic                in_bounds;
    logic                cell_value;
    logic                walkable;
    logic                neighbour_valid;
    logic [NB_OUT_W-1:0] neighbour_x;
    logic [NB_OUT_W-1:0] neighbour_y;
    logic                last;
  } out_item_t;

  // Classified command: centre and neighbours already checked against the grid
  typedef struct packed {
    kind_e                       kind;
    logic                        ib;
    logic                        val;
    logic                        wonly;
    logic [CRD_W-1:0]            cx;
    logic [CRD_W-1:0]            cy;
    logic [NB_N-1:0]             nb_in;
    logic [NB_N-1:0][CRD_W-1:0]  nx;
    logic [NB_N-1:0][CRD_W-1:0]  ny;
  } qentry_t;

endpackage

// ===== rtl/core/occ_front.sv =====
// ----------------------------------------------------------------------------
// occ_front
// Input side: accepts items, drops unused kinds, checks the point and its
// four neighbours against the active grid size and pushes a command.
// ----------------------------------------------------------------------------
module occ_front #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  occ_pkg::in_item_t          in_item_i,
  input  logic [occ_pkg::CFG_W-1:0]  grid_width_i,
  input  logic [occ_pkg::CFG_W-1:0]  grid_height_i,
  input  logic                       q_full_i,
  input  logic                       clearing_i,
  output logic                       push_o,
  output occ_pkg::qentry_t           entry_o
);
  import occ_pkg::*;

  logic [CFG_W-1:0]  eff_w, eff_h;
  logic signed [9:0] sx, sy;
  logic signed [9:0] nbx [NB_N];
  logic signed [9:0] nby [NB_N];
  kind_e             kind;

  function automatic logic in_grid(logic signed [9:0] x, logic signed [9:0] y,
                                   logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    logic signed [9:0] sw, sh;
    sw = $signed({3'b000, w});
    sh = $signed({3'b000, h});
    return (x >= 10'sd0) && (x < sw) && (y >= 10'sd0) && (y < sh);
  endfunction

  assign eff_w = (grid_width_i  > CFG_W'(MAX_WIDTH))  ? CFG_W'(MAX_WIDTH)  : grid_width_i;
  assign eff_h = (grid_height_i > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : grid_height_i;

  assign sx   = {{2{in_item_i.pos_x[7]}}, in_item_i.pos_x};
  assign sy   = {{2{in_item_i.pos_y[7]}}, in_item_i.pos_y};
  assign kind = kind_e'(in_item_i.kind);

  // Order: +x, -x, +y, -y
  assign nbx[0] = sx + 10'sd1;
  assign nbx[1] = sx - 10'sd1;
  assign nbx[2] = sx;
  assign nbx[3] = sx;
  assign nby[0] = sy;
  assign nby[1] = sy;
  assign nby[2] = sy + 10'sd1;
  assign nby[3] = sy - 10'sd1;

  assign in_ready_o = !q_full_i && !clearing_i;
  assign push_o     = in_valid_i && in_ready_o && (kind != KIND_NONE);

  always_comb begin
    entry_o.kind  = kind;
    entry_o.ib    = in_grid(sx, sy, eff_w, eff_h);
    entry_o.val   = in_item_i.obstacle_value;
    entry_o.wonly = in_item_i.skip_blocked;
    entry_o.cx    = sx[CRD_W-1:0];
    entry_o.cy    = sy[CRD_W-1:0];
    for (int i = 0; i < NB_N; i++) begin
      entry_o.nb_in[i] = entry_o.ib && in_grid(nbx[i], nby[i], eff_w, eff_h);
      entry_o.nx[i]    = nbx[i][CRD_W-1:0];
      entry_o.ny[i]    = nby[i][CRD_W-1:0];
    end
  end

endmodule

// ===== rtl/core/occ_queue.sv =====
// ----------------------------------------------------------------------------
// occ_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module occ_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  occ_pkg::qentry_t  entry_i,
  input  logic              pop_i,
  output occ_pkg::qentry_t  entry_o,
  output logic              full_o,
  output logic              empty_o
);
  import occ_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  qentry_t       mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/core/occ_back.sv =====
// ----------------------------------------------------------------------------
// occ_back
// Execution side: owns the single-port obstacle memory, clears it after
// reset, carries out set, query and neighbour commands and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module occ_back #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  occ_pkg::qentry_t  q_entry_i,
  output logic              pop_o,
  output logic              clearing_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output occ_pkg::out_item_t out_item_o
);
  import occ_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;
  localparam logic [2:0] ST_CALC  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]      st_q, st_d;
  qentry_t         cmd_q, cmd_d;
  logic [2:0]      rd_idx_q, rd_idx_d;
  logic            pend_q;
  logic [2:0]      pend_idx_q;
  logic [NB_N:0]   bits_q;
  logic [NB_N-1:0] rem_q, rem_d;
  logic            cv_q, cv_d;
  logic [AW-1:0]   clr_cnt_q, clr_cnt_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic            mem [DEPTH];
  logic            rdata_q;
  logic            we, re, wd;
  logic [AW-1:0]   addr;
  logic [2:0]      last_idx;
  logic [1:0]      sel;
  logic            out_free;

  function automatic logic [AW-1:0] addr_of(logic [CRD_W-1:0] x, logic [CRD_W-1:0] y);
    return AW'(int'(y) * MAX_WIDTH + int'(x));
  endfunction

  assign out_free    = !out_valid_q || out_ready_i;
  assign clearing_o  = (st_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign pop_o       = (st_q == ST_IDLE) && !q_empty_i;

  // Neighbour cells are read only when obstacles are to be skipped
  assign last_idx = (cmd_q.kind == KIND_NBR && cmd_q.ib && cmd_q.wonly) ? 3'd4 : 3'd0;

  // Lowest remaining neighbour
  always_comb begin
    sel = '0;
    for (int i = NB_N - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        sel = 2'(i);
      end
    end
  end

  always_comb begin
    st_d        = st_q;
    cmd_d       = cmd_q;
    rd_idx_d    = rd_idx_q;
    rem_d       = rem_q;
    cv_d        = cv_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    re          = 1'b0;
    wd          = 1'b0;
    addr        = addr_of(cmd_q.cx, cmd_q.cy);

    case (st_q)
      ST_CLEAR: begin
        we        = 1'b1;
        addr      = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          cmd_d    = q_entry_i;
          rd_idx_d = '0;
          st_d     = ST_READ;
        end
      end
      ST_READ: begin
        if (cmd_q.kind == KIND_SET) begin
          we    = cmd_q.ib;
          wd    = cmd_q.val;
          cv_d  = cmd_q.ib ? cmd_q.val : 1'b1;
          rem_d = '0;
          st_d  = ST_EMIT;
        end else begin
          if (rd_idx_q == 3'd0) begin
            re = cmd_q.ib;
          end else begin
            re   = cmd_q.nb_in[2'(rd_idx_q - 3'd1)];
            addr = addr_of(cmd_q.nx[2'(rd_idx_q - 3'd1)], cmd_q.ny[2'(rd_idx_q - 3'd1)]);
          end
          if (rd_idx_q == last_idx) begin
            st_d = ST_FIN;
          end else begin
            rd_idx_d = rd_idx_q + 3'd1;
          end
        end
      end
      ST_FIN: begin
        // last read data lands in bits_q at this edge
        st_d = ST_CALC;
      end
      ST_CALC: begin
        cv_d = cmd_q.ib ? bits_q[0] : 1'b1;
        for (int i = 0; i < NB_N; i++) begin
          rem_d[i] = (cmd_q.kind == KIND_NBR) && cmd_q.nb_in[i] &&
                     !(cmd_q.wonly && bits_q[i+1]);
        end
        st_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.in_bounds     = cmd_q.ib;
          out_d.cell_value    = cv_q;
          out_d.walkable      = cmd_q.ib && !cv_q;
          out_d.neighbour_valid = |rem_q;
          out_d.neighbour_x   = (|rem_q) ? cmd_q.nx[sel][NB_OUT_W-1:0] : '0;
          out_d.neighbour_y   = (|rem_q) ? cmd_q.ny[sel][NB_OUT_W-1:0] : '0;
          out_d.last          = ((rem_q & (rem_q - 4'd1)) == '0);
          rem_d               = rem_q & (rem_q - 4'd1);
          if (out_d.last) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      pend_q      <= re;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rd_idx_q   <= rd_idx_d;
    rem_q      <= rem_d;
    cv_q       <= cv_d;
    out_q      <= out_d;
    pend_idx_q <= rd_idx_q;
    if (pend_q) begin
      bits_q[pend_idx_q] <= rdata_q;
    end
  end

  // Single-port obstacle memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr] <= wd;
    end else if (re) begin
      rdata_q <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/occupancy_grid_store.sv =====
// Throughput: the back part finishes one command before it takes the next from
//   the queue; it walks the single memory port once per read and emits one
//   result per cycle while out_ready_i is high (a stalled result is held).
// Reset: after rst_ni the obstacle memory is cleared one cell per cycle, all
//   MAX_WIDTH*MAX_HEIGHT cells, with in_ready_o low; registers stay writable.
// ----------------------------------------------------------------------------
// occupancy_grid_store
// One-bit obstacle map with set, query and four-neighbour listing commands
// and an APB-style port for the active grid size.
// ----------------------------------------------------------------------------
module occupancy_grid_store #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  occ_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output occ_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import occ_pkg::*;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  logic [CFG_W-1:0] grid_width_q, grid_width_d;
  logic [CFG_W-1:0] grid_height_q, grid_height_d;
  logic             cfg_wr;
  logic             push, pop, q_full, q_empty, clearing;
  qentry_t          push_entry, pop_entry;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    grid_width_d  = grid_width_q;
    grid_height_d = grid_height_q;
    if (cfg_wr) begin
      case (paddr[2])
        REG_GRID_WIDTH:  grid_width_d  = pwdata[CFG_W-1:0];
        REG_GRID_HEIGHT: grid_height_d = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_GRID_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, grid_width_q};
      REG_GRID_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, grid_height_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= CFG_W'(64);
      grid_height_q <= CFG_W'(64);
    end else begin
      grid_width_q  <= grid_width_d;
      grid_height_q <= grid_height_d;
    end
  end

  occ_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .grid_width_i (grid_width_q),
    .grid_height_i(grid_height_q),
    .q_full_i     (q_full),
    .clearing_i   (clearing),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  occ_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .entry_o(pop_entry),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  occ_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_entry_i  (pop_entry),
    .pop_o      (pop),
    .clearing_o (clearing),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== rtl/core/occ_checker.sv =====
// ----------------------------------------------------------------------------
// occ_checker
// Port-level checks on the result channel of the occupancy grid store.
// ----------------------------------------------------------------------------
module occ_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input occ_pkg::out_item_t out_item_o
);
  import occ_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_walkable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.walkable |->
      out_item_o.in_bounds && !out_item_o.cell_value)
    else $error("walkable cell out of bounds or blocked");

  a_empty_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.neighbour_valid |->
      out_item_o.last && out_item_o.neighbour_x == '0 && out_item_o.neighbour_y == '0)
    else $error("empty result not final or carries coordinates");

  a_nbr_centre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.neighbour_valid |-> out_item_o.in_bounds)
    else $error("neighbour listed for a centre outside the grid");

endmodule

bind occupancy_grid_store occ_checker u_occ_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);

// ===== verif/occupancy_grid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_checker
// Watches both channels and the configuration port of the occupancy grid
// store. Keeps its own copy of the obstacle map and grid size, predicts the
// results of each accepted command and compares them field by field.
// ----------------------------------------------------------------------------
package occ_tb_pkg;

  localparam logic [2:0] ADDR_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_GRID_HEIGHT = 3'd4;

endpackage

module occupancy_grid_checker #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  occ_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  occ_pkg::out_item_t out_item_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [2:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output int                 mismatches_o,
  output int                 pending_o
);

  import occ_pkg::*;
  import occ_tb_pkg::*;

  logic       obstacle_map [MAX_WIDTH*MAX_HEIGHT];
  logic [6:0] grid_cols;
  logic [6:0] grid_rows;
  out_item_t  awaited_results [$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  function automatic int active_cols();
    return (grid_cols > MAX_WIDTH) ? MAX_WIDTH : int'(grid_cols);
  endfunction

  function automatic int active_rows();
    return (grid_rows > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_rows);
  endfunction

  function automatic bit on_grid(int x, int y);
    return x >= 0 && x < active_cols() && y >= 0 && y < active_rows();
  endfunction

  function automatic void compare_field(string name, logic [5:0] want, logic [5:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endfunction

  // Append one result to the tail of the awaited list
  function automatic void enqueue_result(out_item_t res);
    awaited_results.insert(awaited_results.size(), res);
  endfunction

  // Apply one command to the map copy and queue the results it must produce
  function automatic void predict_grid_results(in_item_t cmd);
    int        step_x [4] = '{1, -1, 0, 0};
    int        step_y [4] = '{0, 0, 1, -1};
    int        x;
    int        y;
    int        cx;
    int        cy;
    int        listed;
    logic      ib;
    logic      cv;
    out_item_t res;
    if (cmd.kind == KIND_NONE) return;
    x  = $signed(cmd.pos_x);
    y  = $signed(cmd.pos_y);
    ib = on_grid(x, y);
    if (cmd.kind == KIND_SET && ib) obstacle_map[y*MAX_WIDTH + x] = cmd.obstacle_value;
    cv = ib ? obstacle_map[y*MAX_WIDTH + x] : 1'b1;
    res = '0;
    res.in_bounds  = ib;
    res.cell_value = cv;
    res.walkable   = ib && !cv;
    if (cmd.kind != KIND_NBR) begin
      res.last = 1'b1;
      enqueue_result(res);
      return;
    end
    listed = 0;
    if (ib) begin
      for (int d = 0; d < NB_N; d++) begin
        cx = x + step_x[d];
        cy = y + step_y[d];
        if (on_grid(cx, cy) && !(cmd.skip_blocked && obstacle_map[cy*MAX_WIDTH + cx])) begin
          res.neighbour_valid = 1'b1;
          res.neighbour_x     = cx[5:0];
          res.neighbour_y     = cy[5:0];
          enqueue_result(res);
          listed++;
        end
      end
    end
    if (listed == 0) begin
      res.last = 1'b1;
      enqueue_result(res);
    end else begin
      awaited_results[awaited_results.size()-1].last = 1'b1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      foreach (obstacle_map[i]) obstacle_map[i] = 1'b0;
      grid_cols = 7'd64;
      grid_rows = 7'd64;
      awaited_results.delete();
    end else begin
      // retire the oldest result before a new command adds its own
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing expected: %p", out_item_i);
          mismatches_o++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("in_bounds", want.in_bounds, out_item_i.in_bounds);
          compare_field("cell_value", want.cell_value, out_item_i.cell_value);
          compare_field("walkable", want.walkable, out_item_i.walkable);
          compare_field("neighbour_valid", want.neighbour_valid,
                        out_item_i.neighbour_valid);
          compare_field("neighbour_x", want.neighbour_x, out_item_i.neighbour_x);
          compare_field("neighbour_y", want.neighbour_y, out_item_i.neighbour_y);
          compare_field("last", want.last, out_item_i.last);
        end
      end
      if (in_valid_i && in_ready_i) predict_grid_results(in_item_i);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == ADDR_GRID_WIDTH) grid_cols = pwdata_i[6:0];
        else if (paddr_i == ADDR_GRID_HEIGHT) grid_rows = pwdata_i[6:0];
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

// ===== verif/occupancy_grid_store_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_store_test
// Drives set, query and neighbour commands into the occupancy grid store
// over a series of grid sizes, with random gaps on both channels and one long
// output stall. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module occupancy_grid_store_test;

  import occ_pkg::*;
  import occ_tb_pkg::*;

  localparam int MAX_WIDTH       = 64;
  localparam int MAX_HEIGHT      = 64;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int HOLD_CYCLES     = 200;
  localparam int SETTLE_CYCLES   = 16;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 44;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int pending;
  int quiet_cycles = 0;
  int cur_cols;
  int cur_rows;
  bit steady;
  bit hold_req;

  int width_plan  [PHASES] = '{64, 1, 5, 127, 0, 9, 64, 13, 64};
  int height_plan [PHASES] = '{64, 1, 3, 100, 7, 0, 1, 64, 64};

  occupancy_grid_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  occupancy_grid_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Count cycles without any transfer and give up on a hang
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, one long hold on request, none when steady
  initial begin
    int span;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        span = $urandom_range(1, 16);
        repeat (span - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        span = steady ? 0 : $urandom_range(0, 12);
        repeat (span) @(negedge clk_i);
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, int value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_item(in_item_t cmd);
    int gap;
    @(negedge clk_i);
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every awaited result has been seen
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic in_item_t make_cmd(kind_e k, int x, int y, bit v, bit w);
    in_item_t cmd;
    cmd.kind           = k;
    cmd.pos_x          = x[7:0];
    cmd.pos_y          = y[7:0];
    cmd.obstacle_value = v;
    cmd.skip_blocked   = w;
    return cmd;
  endfunction

  // Mostly just inside or around the grid, sometimes anywhere in range
  function automatic int pick_coord(int span);
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 255)) - 128;
    return int'($urandom_range(0, span + 1)) - 1;
  endfunction

  function automatic in_item_t random_cmd();
    int    r;
    kind_e k;
    r = $urandom_range(0, 99);
    if (r < 35) k = KIND_SET;
    else if (r < 60) k = KIND_QUERY;
    else if (r < 95) k = KIND_NBR;
    else k = KIND_NONE;
    return make_cmd(k, pick_coord(cur_cols), pick_coord(cur_rows),
                    $urandom_range(0, 1), $urandom_range(0, 1));
  endfunction

  initial begin
    int       sent;
    in_item_t cmd;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    steady     = 1'b0;
    hold_req   = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES - 1) steady = 1'b1;
      apb_write(ADDR_GRID_WIDTH, width_plan[phase]);
      apb_write(ADDR_GRID_HEIGHT, height_plan[phase]);
      cur_cols = (width_plan[phase] > MAX_WIDTH) ? MAX_WIDTH : width_plan[phase];
      cur_rows = (height_plan[phase] > MAX_HEIGHT) ? MAX_HEIGHT : height_plan[phase];

      if (phase == 0) begin
        // corners, writes off the grid, extremes of both coordinates
        send_item(make_cmd(KIND_SET, 0, 0, 1, 0));
        send_item(make_cmd(KIND_SET, 63, 63, 1, 1));
        send_item(make_cmd(KIND_SET, 63, 0, 1, 0));
        send_item(make_cmd(KIND_SET, 0, 63, 0, 0));
        send_item(make_cmd(KIND_SET, 64, 0, 1, 0));
        send_item(make_cmd(KIND_SET, -128, -128, 1, 1));
        send_item(make_cmd(KIND_QUERY, 0, 0, 0, 0));
        send_item(make_cmd(KIND_QUERY, 63, 63, 1, 1));
        send_item(make_cmd(KIND_QUERY, 0, 63, 0, 0));
        send_item(make_cmd(KIND_QUERY, 64, 0, 0, 0));
        send_item(make_cmd(KIND_QUERY, -1, 5, 0, 0));
        send_item(make_cmd(KIND_QUERY, 127, 127, 1, 1));
        send_item(make_cmd(KIND_QUERY, 5, -128, 0, 0));
        // neighbour lists: corner, obstacle skipped, full, empty, off grid
        send_item(make_cmd(KIND_NBR, 0, 0, 0, 0));
        send_item(make_cmd(KIND_NBR, 62, 63, 0, 1));
        send_item(make_cmd(KIND_NBR, 5, 5, 0, 0));
        send_item(make_cmd(KIND_SET, 1, 0, 1, 0));
        send_item(make_cmd(KIND_SET, 0, 1, 1, 0));
        send_item(make_cmd(KIND_NBR, 0, 0, 0, 1));
        send_item(make_cmd(KIND_NBR, -1, -1, 0, 0));
        send_item(make_cmd(KIND_NONE, 10, 10, 1, 1));
        send_item(make_cmd(KIND_NBR, 63, 0, 0, 0));
        send_item(make_cmd(KIND_SET, 0, 0, 0, 0));
        send_item(make_cmd(KIND_QUERY, 0, 0, 0, 0));
      end

      // hold the result side so the block backs up into its input
      if (phase == 3) hold_req = 1'b1;

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        cmd = random_cmd();
        send_item(cmd);
        if (cmd.kind != KIND_NONE) sent++;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
